// ----- hdl/mprw_pkg.sv -----
// ============================================================================
// mprw_pkg
// Shared types for the multipath RDMA receive window: controller states,
// answer codes and the command and status groups between the two halves.
// ============================================================================
package mprw_pkg;

   // Answer code carried in the verdict field of every result beat.
   typedef enum logic [1:0] {
      VERDICT_ACK  = 2'd0,
      VERDICT_NACK = 2'd1,
      VERDICT_OOW  = 2'd2,
      VERDICT_DUP  = 2'd3
   } verdict_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_SETUP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        clear_step;
      logic        lookup;
      logic        mark;
      logic        setup;
      logic        scan_rd;
      logic        scan_next;
      logic        finish;
      logic        set_verdict;
      verdict_type verdict;
      logic        bump;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_of_window;
      logic below_base;
      logic bit_set;
      logic sync;
      logic scan_end;
      logic in_dist;
   } status_type;

endpackage

// ----- hdl/mprw_ram.sv -----
// ============================================================================
// mprw_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module mprw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mprw_ctrl.sv -----
// ============================================================================
// mprw_ctrl
// Controller of the receive window: clearing pass, bitmap lookup and mark,
// the sync scan one slot at a time, and the one-cycle result beat.
// ============================================================================
module mprw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   input  mprw_pkg::status_type status,
   output mprw_pkg::cmd_type   cmd
);
   import mprw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (status.out_of_window) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = VERDICT_OOW;
               state_in        = ST_RESULT;
            end else if (status.below_base) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = VERDICT_DUP;
               state_in        = ST_RESULT;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bit_set) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = VERDICT_DUP;
               state_in        = ST_RESULT;
            end else begin
               cmd.mark = 1'b1;
               if (status.sync) begin
                  state_in = ST_SETUP;
               end else begin
                  cmd.set_verdict = 1'b1;
                  cmd.verdict     = VERDICT_ACK;
                  state_in        = ST_RESULT;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (status.scan_end) begin
               cmd.finish      = 1'b1;
               cmd.set_verdict = 1'b1;
               cmd.verdict     = VERDICT_ACK;
               state_in        = ST_RESULT;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (!status.bit_set) begin
               // A hole inside the sync distance fails the sync.
               cmd.finish      = 1'b1;
               cmd.set_verdict = 1'b1;
               cmd.verdict     = status.in_dist ? VERDICT_NACK : VERDICT_ACK;
               state_in        = ST_RESULT;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_RESULT: begin
            cmd.bump = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESULT);

endmodule

// ----- hdl/mprw_dp.sv -----
// ============================================================================
// mprw_dp
// Datapath of the receive window: packet fields, window registers, the
// received bitmap memory, the scan pointer and the result fields.
// ============================================================================
module mprw_dp #(
   parameter int WINDOW_SLOTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mprw_pkg::cmd_type    cmd,
   output mprw_pkg::status_type status,
   input  logic [31:0]          req_seq_number,
   input  logic                 req_sync_flag,
   input  logic                 req_retx_flag,
   input  logic [1:0]           req_ecn_bits,
   input  logic [15:0]          req_priority_group,
   input  logic [15:0]          req_source_port,
   input  logic [15:0]          req_dest_port,
   input  logic                 csr_wr_en,
   input  logic [6:0]           csr_wr_data,
   output logic [1:0]           rsp_verdict,
   output logic [31:0]          rsp_ack_seq,
   output logic [31:0]          rsp_cumulative_ack,
   output logic                 rsp_cnp_flag,
   output logic                 rsp_retx_echo,
   output logic [15:0]          rsp_group_echo,
   output logic [15:0]          rsp_ack_source_port,
   output logic [15:0]          rsp_ack_dest_port,
   output logic [15:0]          rsp_ack_ident
);
   import mprw_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_SLOTS);
   localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_SLOTS - 1);
   localparam logic [IDX_W:0]   SLOTS_X   = (IDX_W + 1)'(WINDOW_SLOTS);
   localparam logic [32:0]      SLOTS_33  = 33'(WINDOW_SLOTS);
   localparam logic [CNT_W-1:0] SLOTS_C   = CNT_W'(WINDOW_SLOTS);
   localparam logic [6:0]       SYNC_DIST_RESET = 7'd16;

   // Captured packet fields.
   logic [31:0] seq_ff;
   logic        sync_ff;
   logic        retx_ff;
   logic [1:0]  ecn_ff;
   logic [15:0] group_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;

   // Window state and configuration.
   logic [31:0]      base_ff,  base_in;
   logic [IDX_W-1:0] head_ff,  head_in;
   logic [31:0]      hs_ff,    hs_in;
   logic [15:0]      ident_ff, ident_in;
   logic [6:0]       dist_ff,  dist_in;

   // Scan and lookup registers.
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] ptr_ff,  ptr_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [CNT_W-1:0] span_ff, span_in;
   verdict_type      verdict_ff, verdict_in;

   // Lookup arithmetic.
   logic [31:0]      offset;
   logic [IDX_W:0]   slot_sum;
   logic [IDX_W:0]   slot_wrap;
   logic [IDX_W-1:0] ptr_next;
   logic [32:0]      hs_plus1;
   logic [32:0]      span_diff;
   logic [CNT_W-1:0] span_calc;
   logic             drop;

   // Bitmap memory port signals.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic             ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic             ram_rd_data;

   // Slot of the packet: head plus offset, wrapped once around the ring.
   assign offset    = seq_ff - base_ff;
   assign slot_sum  = {1'b0, head_ff} + {1'b0, offset[IDX_W-1:0]};
   assign slot_wrap = (slot_sum >= SLOTS_X) ? (slot_sum - SLOTS_X) : slot_sum;
   assign ptr_next  = (ptr_ff == LAST_SLOT) ? '0 : (ptr_ff + 1'b1);

   // Scan length: received span above the base, at most one full window.
   assign hs_plus1  = {1'b0, hs_ff} + 33'd1;
   assign span_diff = hs_plus1 - {1'b0, base_ff};
   always_comb begin
      if (hs_plus1 <= {1'b0, base_ff}) begin
         span_calc = '0;
      end else if (span_diff >= SLOTS_33) begin
         span_calc = SLOTS_C;
      end else begin
         span_calc = span_diff[CNT_W-1:0];
      end
   end

   // Status toward the controller.
   always_comb begin
      status.clear_last    = (ptr_ff == LAST_SLOT);
      status.out_of_window = ({1'b0, seq_ff} >= ({1'b0, base_ff} + SLOTS_33));
      status.below_base    = (seq_ff < base_ff);
      status.bit_set       = ram_rd_data;
      status.sync          = sync_ff;
      status.scan_end      = (cnt_ff == span_ff);
      status.in_dist       = (32'(cnt_ff) < 32'(dist_ff));
   end

   // Bitmap port selection: clear pass and scan clear at the pointer,
   // marking at the looked-up slot.
   always_comb begin
      ram_wr_en   = cmd.clear_step | cmd.mark | cmd.scan_next;
      ram_wr_addr = cmd.mark ? slot_ff : ptr_ff;
      ram_wr_data = cmd.mark;
      ram_rd_addr = cmd.lookup ? slot_wrap[IDX_W-1:0] : ptr_ff;
   end

   mprw_ram #(
      .WIDTH (1),
      .DEPTH (WINDOW_SLOTS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign drop = (verdict_ff == VERDICT_OOW) || (verdict_ff == VERDICT_DUP);

   // Next values of the window and scan registers.
   always_comb begin
      base_in    = base_ff;
      head_in    = head_ff;
      hs_in      = hs_ff;
      ident_in   = ident_ff;
      dist_in    = dist_ff;
      slot_in    = slot_ff;
      ptr_in     = ptr_ff;
      cnt_in     = cnt_ff;
      span_in    = span_ff;
      verdict_in = verdict_ff;
      if (csr_wr_en) begin
         dist_in = csr_wr_data;
      end
      if (cmd.clear_step) begin
         ptr_in = ptr_next;
      end
      if (cmd.lookup) begin
         slot_in = slot_wrap[IDX_W-1:0];
      end
      if (cmd.mark && (seq_ff > hs_ff)) begin
         hs_in = seq_ff;
      end
      if (cmd.setup) begin
         span_in = span_calc;
         cnt_in  = '0;
         ptr_in  = head_ff;
      end
      if (cmd.scan_next) begin
         cnt_in = cnt_ff + 1'b1;
         ptr_in = ptr_next;
      end
      // The pointer already sits on the new head slot.
      if (cmd.finish) begin
         base_in = base_ff + 32'(cnt_ff);
         head_in = ptr_ff;
      end
      if (cmd.set_verdict) begin
         verdict_in = cmd.verdict;
      end
      if (cmd.bump && !drop) begin
         ident_in = ident_ff + 16'd1;
      end
   end

   // Window state, configuration and clear pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         head_ff  <= '0;
         hs_ff    <= '0;
         ident_ff <= '0;
         dist_ff  <= SYNC_DIST_RESET;
         ptr_ff   <= '0;
      end else begin
         base_ff  <= base_in;
         head_ff  <= head_in;
         hs_ff    <= hs_in;
         ident_ff <= ident_in;
         dist_ff  <= dist_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      cnt_ff     <= cnt_in;
      span_ff    <= span_in;
      verdict_ff <= verdict_in;
      if (cmd.capture) begin
         seq_ff   <= req_seq_number;
         sync_ff  <= req_sync_flag;
         retx_ff  <= req_retx_flag;
         ecn_ff   <= req_ecn_bits;
         group_ff <= req_priority_group;
         sport_ff <= req_source_port;
         dport_ff <= req_dest_port;
      end
   end

   // Result fields; a dropped packet reports its verdict and zeros.
   always_comb begin
      rsp_verdict         = verdict_ff;
      rsp_ack_seq         = drop ? '0 : seq_ff;
      rsp_cumulative_ack  = drop ? '0 : base_ff;
      rsp_cnp_flag        = drop ? 1'b0 : (ecn_ff != 2'd0);
      rsp_retx_echo       = drop ? 1'b0 : retx_ff;
      rsp_group_echo      = drop ? '0 : group_ff;
      rsp_ack_source_port = drop ? '0 : dport_ff;
      rsp_ack_dest_port   = drop ? '0 : sport_ff;
      rsp_ack_ident       = drop ? '0 : ident_ff;
   end

endmodule

// ----- hdl/multipath_rdma_receive_window.sv -----
// ============================================================================
// multipath_rdma_receive_window
// Receiver window of one multipath RDMA queue pair: bitmap of received
// sequence slots, duplicate and out-of-window drops, sync with ACK or NACK.
// ============================================================================
// Usage:
//   A packet beat is taken at a clock edge with start high and busy low.
//   Exactly one result beat follows on the rsp_ ports, marked by rsp_valid
//   for one cycle; the receiver cannot hold it off. sync_distance is written
//   through csr_wr_en / csr_wr_data while the block is idle.
// Steps, counted from accept to the next accept:
//   an out-of-window or below-window drop passes lookup and result; an
//   ordinary packet or bitmap duplicate passes lookup, check and result.
//   A newly marked sync packet then takes a setup step and a scan that
//   reads and checks one slot at a time, clearing each received slot,
//   until it reaches the end of the received span or a hole. The bitmap
//   memory has one read and one write port.
// Reset:
//   Synchronous. Afterwards busy stays high while a clearing pass zeroes the
//   bitmap; configuration writes are taken then.
// ============================================================================
module multipath_rdma_receive_window #(
   parameter int WINDOW_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_seq_number,
   input  logic        req_sync_flag,
   input  logic        req_retx_flag,
   input  logic [1:0]  req_ecn_bits,
   input  logic [15:0] req_priority_group,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   output logic        rsp_valid,
   output logic [1:0]  rsp_verdict,
   output logic [31:0] rsp_ack_seq,
   output logic [31:0] rsp_cumulative_ack,
   output logic        rsp_cnp_flag,
   output logic        rsp_retx_echo,
   output logic [15:0] rsp_group_echo,
   output logic [15:0] rsp_ack_source_port,
   output logic [15:0] rsp_ack_dest_port,
   output logic [15:0] rsp_ack_ident,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import mprw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of lookup, mark, scan and result.
   mprw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Window registers, bitmap and result fields.
   mprw_dp #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_seq_number      (req_seq_number),
      .req_sync_flag       (req_sync_flag),
      .req_retx_flag       (req_retx_flag),
      .req_ecn_bits        (req_ecn_bits),
      .req_priority_group  (req_priority_group),
      .req_source_port     (req_source_port),
      .req_dest_port       (req_dest_port),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_verdict         (rsp_verdict),
      .rsp_ack_seq         (rsp_ack_seq),
      .rsp_cumulative_ack  (rsp_cumulative_ack),
      .rsp_cnp_flag        (rsp_cnp_flag),
      .rsp_retx_echo       (rsp_retx_echo),
      .rsp_group_echo      (rsp_group_echo),
      .rsp_ack_source_port (rsp_ack_source_port),
      .rsp_ack_dest_port   (rsp_ack_dest_port),
      .rsp_ack_ident       (rsp_ack_ident)
   );

endmodule

// ----- hdl/mprw_checker.sv -----
// ============================================================================
// mprw_checker
// Port-level checks of the receive window, attached to the top level.
// ============================================================================
module mprw_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_verdict,
   input logic [31:0] rsp_ack_seq,
   input logic [31:0] rsp_cumulative_ack,
   input logic [15:0] rsp_ack_ident
);

   // An accepted packet keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted beat");

   // A result beat only appears while a packet is being worked on.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy && $past(busy)))
      else $error("result beat without a packet in flight");

   // One result beat per packet, after which the block is free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result beat longer than one cycle");

   // A dropped packet reports its verdict with zero sequence, cumulative ACK and ident.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict[1]) |->
         (rsp_ack_seq == 32'd0 && rsp_cumulative_ack == 32'd0 &&
          rsp_ack_ident == 16'd0))
      else $error("dropped packet carries nonzero fields");

endmodule

bind multipath_rdma_receive_window mprw_checker u_mprw_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the multipath RDMA receive window. Packet beats are
// sent in random bursts, and a bit-level model of the received bitmap, window
// head and sync scan predicts every answer beat. The answer beats are then
// compared field by field, in order. The sync distance is changed between
// phases while the window is idle.
// ============================================================================
module tb_top;
   import mprw_pkg::*;

   localparam int WINDOW_SLOTS = 64;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int PRINT_LIMIT  = 40;

   // One data packet as it enters the window.
   typedef struct packed {
      logic [31:0] seq;
      logic        sync;
      logic        retx;
      logic [1:0]  ecn;
      logic [15:0] group;
      logic [15:0] sport;
      logic [15:0] dport;
   } data_packet_type;

   // One answer beat as the window should produce it.
   typedef struct packed {
      verdict_type verdict;
      logic [31:0] ack_seq;
      logic [31:0] cum_ack;
      logic        cnp;
      logic        retx;
      logic [15:0] group;
      logic [15:0] ack_sport;
      logic [15:0] ack_dport;
      logic [15:0] ident;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_seq_number;
   logic        req_sync_flag;
   logic        req_retx_flag;
   logic [1:0]  req_ecn_bits;
   logic [15:0] req_priority_group;
   logic [15:0] req_source_port;
   logic [15:0] req_dest_port;
   logic        rsp_valid;
   logic [1:0]  rsp_verdict;
   logic [31:0] rsp_ack_seq;
   logic [31:0] rsp_cumulative_ack;
   logic        rsp_cnp_flag;
   logic        rsp_retx_echo;
   logic [15:0] rsp_group_echo;
   logic [15:0] rsp_ack_source_port;
   logic [15:0] rsp_ack_dest_port;
   logic [15:0] rsp_ack_ident;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;

   // Window model state, mirrored from the block's reset values.
   bit          seen_map [WINDOW_SLOTS];
   bit   [31:0] win_base;
   bit   [5:0]  head_slot;
   bit   [31:0] top_seq;
   bit   [15:0] next_ident;
   bit   [6:0]  sync_dist = 7'd16;

   answer_type  answers_due [$];
   answer_type  oldest_answer;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          burst_left = 0;

   multipath_rdma_receive_window #(
      .WINDOW_SLOTS(WINDOW_SLOTS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_seq_number      (req_seq_number),
      .req_sync_flag       (req_sync_flag),
      .req_retx_flag       (req_retx_flag),
      .req_ecn_bits        (req_ecn_bits),
      .req_priority_group  (req_priority_group),
      .req_source_port     (req_source_port),
      .req_dest_port       (req_dest_port),
      .rsp_valid           (rsp_valid),
      .rsp_verdict         (rsp_verdict),
      .rsp_ack_seq         (rsp_ack_seq),
      .rsp_cumulative_ack  (rsp_cumulative_ack),
      .rsp_cnp_flag        (rsp_cnp_flag),
      .rsp_retx_echo       (rsp_retx_echo),
      .rsp_group_echo      (rsp_group_echo),
      .rsp_ack_source_port (rsp_ack_source_port),
      .rsp_ack_dest_port   (rsp_ack_dest_port),
      .rsp_ack_ident       (rsp_ack_ident),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // Updates the window model with one accepted packet and returns its answer.
   function automatic answer_type predict_answer(input data_packet_type p);
      answer_type      a;
      longint unsigned offset;
      longint unsigned span;
      longint unsigned scan_len;
      longint unsigned i;
      longint unsigned step;
      a = '0;
      if (64'(p.seq) >= 64'(win_base) + WINDOW_SLOTS) begin
         a.verdict = VERDICT_OOW;
         return a;
      end
      offset = 64'(p.seq) - 64'(win_base);
      if (p.seq < win_base || seen_map[head_slot + 6'(offset)]) begin
         a.verdict = VERDICT_DUP;
         return a;
      end
      if (p.seq > top_seq)
         top_seq = p.seq;
      seen_map[head_slot + 6'(offset)] = 1'b1;
      a.verdict = VERDICT_ACK;

      // Sync: clear the head run; a hole inside the distance stops the window there.
      if (p.sync) begin
         span = 0;
         if (64'(top_seq) + 1 > 64'(win_base))
            span = 64'(top_seq) + 1 - 64'(win_base);
         if (span > WINDOW_SLOTS)
            span = WINDOW_SLOTS;
         scan_len = (64'(sync_dist) < span) ? 64'(sync_dist) : span;
         i = 0;
         while (i < scan_len && seen_map[head_slot + 6'(i)]) begin
            seen_map[head_slot + 6'(i)] = 1'b0;
            i++;
         end
         if (i < scan_len) begin
            a.verdict = VERDICT_NACK;
            step = i;
         end else begin
            // The whole distance was there, so keep going over received slots.
            step = scan_len;
            i = 64'(sync_dist);
            while (i < span && seen_map[head_slot + 6'(i)]) begin
               seen_map[head_slot + 6'(i)] = 1'b0;
               step++;
               i++;
            end
         end
         win_base  = win_base + 32'(step);
         head_slot = head_slot + 6'(step);
      end

      a.ack_seq   = p.seq;
      a.cum_ack   = win_base;
      a.cnp       = (p.ecn != 2'd0);
      a.retx      = p.retx;
      a.group     = p.group;
      a.ack_sport = p.dport;
      a.ack_dport = p.sport;
      a.ident     = next_ident;
      next_ident  = next_ident + 16'd1;
      return a;
   endfunction

   function automatic data_packet_type make_packet(input logic [31:0] seq, input bit sync);
      data_packet_type p;
      p.seq   = seq;
      p.sync  = sync;
      p.retx  = 1'($urandom_range(0, 1));
      p.ecn   = 2'($urandom_range(0, 3));
      p.group = 16'($urandom);
      p.sport = 16'($urandom);
      p.dport = 16'($urandom);
      return p;
   endfunction

   // Sends one packet beat. Returns in the cycle it was taken, with start still
   // high unless an idle gap followed; the caller then sends again or drains.
   task automatic send_packet(input data_packet_type p, input bit may_idle);
      int         gap;
      answer_type due;
      req_seq_number     <= p.seq;
      req_sync_flag      <= p.sync;
      req_retx_flag      <= p.retx;
      req_ecn_bits       <= p.ecn;
      req_priority_group <= p.group;
      req_source_port    <= p.sport;
      req_dest_port      <= p.dport;
      start              <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      due = predict_answer(p);
      answers_due.insert(answers_due.size(), due);

      // Bursts of random length; some are long stretches with no gap at all.
      if (may_idle) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stops sending and waits until every answer is in and the block is idle.
   task automatic drain_answers();
      start <= 1'b0;
      while (answers_due.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_sync_distance(input logic [6:0] value);
      drain_answers();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sync_dist = value;
   endtask

   // Window bounds, field extremes, duplicates and a NACK at the default distance.
   task automatic test_window_edges();
      data_packet_type p;
      send_packet('{32'd0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, 1'b1);
      send_packet(make_packet(32'd0, 1'b0), 1'b1);
      send_packet(make_packet(32'd64, 1'b0), 1'b1);
      send_packet('{32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
      send_packet('{32'd63, 1'b0, 1'b1, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
      p = make_packet(32'd1, 1'b1);
      p.ecn = 2'd1;
      send_packet(p, 1'b1);
      send_packet(make_packet(32'd1, 1'b0), 1'b1);
      p = make_packet(32'd65, 1'b0);
      p.ecn = 2'd2;
      send_packet(p, 1'b1);
      send_packet(make_packet(32'd66, 1'b0), 1'b1);
   endtask

   // A short distance that is fully received, so the sync ends in an ACK.
   task automatic test_short_sync();
      write_sync_distance(7'd4);
      for (int k = 2; k < 5; k++)
         send_packet(make_packet(32'(k), 1'b0), 1'b1);
      send_packet(make_packet(32'd5, 1'b1), 1'b1);
   endtask

   // With a zero distance the sync only slides over the received head run.
   task automatic test_sync_zero();
      write_sync_distance(7'd0);
      send_packet(make_packet(32'd6, 1'b1), 1'b1);
      send_packet(make_packet(32'd9, 1'b1), 1'b1);
   endtask

   // A distance beyond the received span is cut down to that span.
   task automatic test_sync_span_limit();
      write_sync_distance(7'd127);
      send_packet(make_packet(32'd7, 1'b1), 1'b1);
      send_packet(make_packet(32'd8, 1'b1), 1'b1);
   endtask

   // Mostly in-window traffic and in-order runs closed by a sync, with some
   // duplicates below the window, near misses above it and fully random numbers.
   task automatic test_random_traffic(input logic [6:0] distance, input int count);
      data_packet_type p;
      int              r;
      int              run_len;
      int              sent;
      logic [31:0]     run_base;
      write_sync_distance(distance);
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            run_len  = $urandom_range(2, 64);
            run_base = win_base;
            for (int k = 0; k < run_len; k++)
               send_packet(make_packet(run_base + 32'(k), k == run_len - 1), 1'b1);
            sent += run_len;
         end else begin
            if (r < 72)
               p = make_packet(win_base + $urandom_range(0, $urandom_range(0, 63)),
                               $urandom_range(0, 4) == 0);
            else if (r < 80 && win_base != 0)
               p = make_packet(win_base - $urandom_range(1, (win_base < 200) ? win_base : 200),
                               1'($urandom_range(0, 1)));
            else if (r < 88)
               p = make_packet(win_base + 64 + $urandom_range(0, 7),
                               1'($urandom_range(0, 1)));
            else
               p = make_packet($urandom, 1'($urandom_range(0, 1)));
            send_packet(p, 1'b1);
            sent++;
         end
         if ($urandom_range(0, 149) == 0)
            drain_answers();
      end
   endtask

   task automatic finish_run();
      drain_answers();
      repeat (10) @(posedge clock);
      if (answers_due.size() != 0)
         report_mismatch($sformatf("%0d answers never arrived", answers_due.size()));
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   endtask

   // Answer checker: each beat is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            report_mismatch("answer beat with no packet waiting for it");
         end else begin
            oldest_answer = answers_due.pop_front();
            compare_field("verdict", 32'(rsp_verdict), 32'(oldest_answer.verdict));
            compare_field("ack_seq", rsp_ack_seq, oldest_answer.ack_seq);
            compare_field("cumulative_ack", rsp_cumulative_ack, oldest_answer.cum_ack);
            compare_field("cnp_flag", 32'(rsp_cnp_flag), 32'(oldest_answer.cnp));
            compare_field("retx_echo", 32'(rsp_retx_echo), 32'(oldest_answer.retx));
            compare_field("group_echo", 32'(rsp_group_echo), 32'(oldest_answer.group));
            compare_field("ack_source_port", 32'(rsp_ack_source_port),
                          32'(oldest_answer.ack_sport));
            compare_field("ack_dest_port", 32'(rsp_ack_dest_port),
                          32'(oldest_answer.ack_dport));
            compare_field("ack_ident", 32'(rsp_ack_ident), 32'(oldest_answer.ident));
         end
      end
   end

   // Test sequence.
   initial begin
      reset              <= 1'b1;
      start              <= 1'b0;
      req_seq_number     <= '0;
      req_sync_flag      <= 1'b0;
      req_retx_flag      <= 1'b0;
      req_ecn_bits       <= '0;
      req_priority_group <= '0;
      req_source_port    <= '0;
      req_dest_port      <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_window_edges();
      test_short_sync();
      test_sync_zero();
      test_sync_span_limit();
      test_random_traffic(7'd1, 200);
      test_random_traffic(7'd64, 200);
      test_random_traffic(7'd127, 150);
      test_random_traffic(7'd0, 150);
      repeat (3)
         test_random_traffic(7'($urandom_range(1, 64)), 150);
      finish_run();
   end

endmodule

// ----- multipath_rdma_receive_window.f -----
hdl/mprw_pkg.sv
hdl/mprw_ram.sv
hdl/mprw_ctrl.sv
hdl/mprw_dp.sv
hdl/multipath_rdma_receive_window.sv
hdl/mprw_checker.sv
tb/tb_top.sv
